// ----- rtl/stpc_pkg.sv -----
// Shared constants for the scan target proximity check.
// Holds field widths, register indexes, reset values and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package stpc_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_HIT_RADIUS  = 2'd2;

  localparam logic [15:0] START_ANGLE_RST = 16'h8000;
  localparam logic [15:0] ANGLE_STEP_RST  = 16'd182;
  localparam logic [15:0] HIT_RADIUS_RST  = 16'd300;

  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 80;

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  function automatic logic signed [31:0] stpc_atan(input logic [4:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/scan_target_proximity_check.sv -----
// Scan target proximity check: per-beam CORDIC projection and hit test, result per scan.
// Depends on stpc_pkg.
//
// Channel   Dir  Signals                               Contents
// s_axis    in   tvalid tready tdata tlast             one lidar beam request
// m_axis    out  tvalid tready tdata tuser             one result per scan
// cfg       in   cfg_we_i cfg_addr_i cfg_wdata_i       register writes
//
// A beam holds s_axis_tready low from its accept until the sequencer is back in idle, so the
// block takes no new beam before it is through with the last one; a last beam adds the output
// state, and on a hit scan the velocity squares and the speed square root. One shared multiplier,
// one CORDIC rotate stage and one square-root step unit are reused under the sequencer.
// Reset clears the sticky hit flag, the output valid and restores register defaults.
// A pending result stalls the last beam in its output state until m_axis_tready.
`default_nettype none

module scan_target_proximity_check #(
  parameter int unsigned MAX_BEAMS       = 2048,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // beam_index, beam_range_mm, ego_x_mm, ego_y_mm, ego_heading, target_x_mm,
  // target_y_mm, target_heading, target_vx_mm_s, target_vy_mm_s, zero fill
  input  wire logic [stpc_pkg::InDataW-1:0]     s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_x_mm, out_y_mm, out_heading, out_speed_mm_s
  output logic [stpc_pkg::OutDataW-1:0]         m_axis_tdata,
  // detected
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [stpc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [stpc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import stpc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ANG  = 4'd1;
  localparam logic [3:0] S_FOLD = 4'd2;
  localparam logic [3:0] S_CORD = 4'd3;
  localparam logic [3:0] S_MULC = 4'd4;
  localparam logic [3:0] S_MULS = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_SQX  = 4'd7;
  localparam logic [3:0] S_SQY  = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_VX   = 4'd10;
  localparam logic [3:0] S_VY   = 4'd11;
  localparam logic [3:0] S_SQRT = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [4:0] LastIter = 5'(TRIG_ITERATIONS - 1);

  logic [3:0]  state_q, state_d;
  logic [15:0] start_q, step_q, radius_q;
  logic        seen_q, seen_d;
  logic        det_q, det_d;

  logic [10:0]        idx_q;
  logic [15:0]        range_q, eh_q, th_q;
  logic signed [23:0] ex_q, ey_q, tx_q, ty_q;
  logic signed [15:0] vx_q, vy_q;
  logic               last_q;

  logic [15:0]        ang_q, ang_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               neg_q, neg_d;
  logic [4:0]         it_q, it_d;
  logic signed [17:0] offx_q, offx_d, offy_q, offy_d;
  logic signed [26:0] dx_q, dx_d, dy_q, dy_d;
  logic [31:0]        r2_q, r2_d;
  logic [53:0]        acc_q, acc_d;
  logic [31:0]        v_q, v_d, r_q, r_d, bit_q, bit_d;

  logic               m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic               m_user_q, m_user_d;

  logic signed [31:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [58:0] prod;
  logic signed [58:0] prod_rnd;
  logic signed [31:0] xs, ys, zfold, trig;
  logic [32:0]        sq_trial;
  logic               in_acc, in_range, hit_now;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign prod     = mul_a * mul_b;
  assign prod_rnd = prod + 59'sd536870912;
  assign xs       = x_q >>> it_q;
  assign ys       = y_q >>> it_q;
  assign zfold    = $signed({ang_q, 16'h0000});
  assign trig     = neg_q ? -x_q : x_q;
  assign sq_trial = {1'b0, r_q} + {1'b0, bit_q};
  assign in_range = {21'd0, idx_q} < 32'(MAX_BEAMS);
  assign hit_now  = in_range && (acc_q < {22'd0, r2_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ANG: begin
        mul_a = $signed({16'd0, step_q});
        mul_b = $signed({16'd0, idx_q});
      end
      S_MULC: begin
        mul_a = trig;
        mul_b = $signed({11'd0, range_q});
      end
      S_MULS: begin
        mul_a = neg_q ? -y_q : y_q;
        mul_b = $signed({11'd0, range_q});
      end
      S_DIFF: begin
        mul_a = $signed({16'd0, radius_q});
        mul_b = $signed({11'd0, radius_q});
      end
      S_SQX: begin
        mul_a = 32'(dx_q);
        mul_b = dx_q;
      end
      S_SQY: begin
        mul_a = 32'(dy_q);
        mul_b = dy_q;
      end
      S_VX: begin
        mul_a = 32'(vx_q);
        mul_b = 27'(vx_q);
      end
      S_VY: begin
        mul_a = 32'(vy_q);
        mul_b = 27'(vy_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    det_d     = det_q;
    ang_d     = ang_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    neg_d     = neg_q;
    it_d      = it_q;
    offx_d    = offx_q;
    offy_d    = offy_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    r2_d      = r2_q;
    acc_d     = acc_q;
    v_d       = v_q;
    r_d       = r_q;
    bit_d     = bit_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ANG;
        end
      end
      S_ANG: begin
        ang_d   = eh_q + start_q + prod[15:0];
        state_d = S_FOLD;
      end
      S_FOLD: begin
        x_d  = CORDIC_X0;
        y_d  = '0;
        it_d = '0;
        if (zfold > 32'sh40000000 || zfold < -32'sh40000000) begin
          z_d   = zfold ^ 32'sh80000000;
          neg_d = 1'b1;
        end else begin
          z_d   = zfold;
          neg_d = 1'b0;
        end
        state_d = S_CORD;
      end
      S_CORD: begin
        if (z_q >= 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - stpc_atan(it_q);
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + stpc_atan(it_q);
        end
        it_d = it_q + 5'd1;
        if (it_q == LastIter) begin
          state_d = S_MULC;
        end
      end
      S_MULC: begin
        offx_d  = prod_rnd[47:30];
        state_d = S_MULS;
      end
      S_MULS: begin
        offy_d  = prod_rnd[47:30];
        state_d = S_DIFF;
      end
      S_DIFF: begin
        dx_d    = 27'(ex_q) + 27'(offx_q) - 27'(tx_q);
        dy_d    = 27'(ey_q) + 27'(offy_q) - 27'(ty_q);
        r2_d    = prod[31:0];
        state_d = S_SQX;
      end
      S_SQX: begin
        acc_d   = {1'b0, prod[52:0]};
        state_d = S_SQY;
      end
      S_SQY: begin
        acc_d   = acc_q + {1'b0, prod[52:0]};
        state_d = S_CMP;
      end
      S_CMP: begin
        if (last_q) begin
          det_d  = seen_q || hit_now;
          seen_d = 1'b0;
          if (seen_q || hit_now) begin
            state_d = S_VX;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          seen_d  = seen_q || hit_now;
          state_d = S_IDLE;
        end
      end
      S_VX: begin
        acc_d   = {22'd0, prod[31:0]};
        state_d = S_VY;
      end
      S_VY: begin
        v_d     = acc_q[31:0] + prod[31:0];
        r_d     = '0;
        bit_d   = 32'h4000_0000;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if ({1'b0, v_q} >= sq_trial) begin
          v_d = v_q - sq_trial[31:0];
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 32'd1) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = det_q;
          if (det_q) begin
            m_data_d = {r_q[15:0], th_q, ty_q, tx_q};
          end else begin
            m_data_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      seen_q    <= 1'b0;
      det_q     <= 1'b0;
      m_valid_q <= 1'b0;
      start_q   <= START_ANGLE_RST;
      step_q    <= ANGLE_STEP_RST;
      radius_q  <= HIT_RADIUS_RST;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      det_q     <= det_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_START_ANGLE: start_q  <= cfg_wdata_i;
          CFG_ANGLE_STEP:  step_q   <= cfg_wdata_i;
          CFG_HIT_RADIUS:  radius_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= s_axis_tdata[10:0];
      range_q <= s_axis_tdata[26:11];
      ex_q    <= s_axis_tdata[50:27];
      ey_q    <= s_axis_tdata[74:51];
      eh_q    <= s_axis_tdata[90:75];
      tx_q    <= s_axis_tdata[114:91];
      ty_q    <= s_axis_tdata[138:115];
      th_q    <= s_axis_tdata[154:139];
      vx_q    <= s_axis_tdata[170:155];
      vy_q    <= s_axis_tdata[186:171];
      last_q  <= s_axis_tlast;
    end
    ang_q    <= ang_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    neg_q    <= neg_d;
    it_q     <= it_d;
    offx_q   <= offx_d;
    offy_q   <= offy_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    r2_q     <= r2_d;
    acc_q    <= acc_d;
    v_q      <= v_d;
    r_q      <= r_d;
    bit_q    <= bit_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for scan_target_proximity_check: directed stimulus table, then
// random lidar scans under several register settings, with randomized stalls on both buses.
// Depends on stpc_pkg and the RTL top level; expected reports: table or local predictor.
`timescale 1ns / 100ps

module testbench;
  import stpc_pkg::*;

  localparam int unsigned MAX_BEAMS       = 2048;
  localparam int unsigned TRIG_ITERATIONS = 16;
  localparam longint      CORDIC_GAIN_X0  = 64'sd652032874;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS     = 131;

  localparam longint ATAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef enum logic { ROW_BEAM, ROW_CFG } row_kind_e;

  typedef struct packed {
    logic signed [15:0] vy;
    logic signed [15:0] vx;
    logic [15:0]        tgt_hdg;
    logic signed [23:0] tgt_y;
    logic signed [23:0] tgt_x;
    logic [15:0]        ego_hdg;
    logic signed [23:0] ego_y;
    logic signed [23:0] ego_x;
    logic [15:0]        range_mm;
    logic [10:0]        index;
    logic               last;
  } beam_t;

  typedef struct packed {
    logic        detected;
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] heading;
    logic [15:0] speed;
  } scan_report_t;

  typedef struct {
    row_kind_e             kind;
    logic [CfgAddrW-1:0]   reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    beam_t                 beam;
    bit                    typed;
    scan_report_t          want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic [15:0]  start_angle_q = START_ANGLE_RST;
  logic [15:0]  angle_step_q  = ANGLE_STEP_RST;
  logic [15:0]  hit_radius_q  = HIT_RADIUS_RST;
  bit           hit_seen_q    = 1'b0;
  bit           burst         = 1'b0;
  scan_report_t scan_reports_q [$];
  stim_row_t    stim_rows [$];
  int unsigned  mismatch_cnt  = 0;
  int unsigned  report_cnt    = 0;
  int unsigned  idle_cycles   = 0;

  scan_target_proximity_check #(
    .MAX_BEAMS      (MAX_BEAMS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void beam_trig(input logic [15:0] ang, output longint cs,
                                    output longint sn);
    longint z, x, y, xs, ys;
    bit     flip;
    int     i;
    z    = longint'({ang, 16'h0000});
    x    = CORDIC_GAIN_X0;
    y    = 0;
    flip = 1'b0;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    if (z > 64'sh4000_0000) begin
      z -= 64'sh8000_0000;
      flip = 1'b1;
    end else if (z < -64'sh4000_0000) begin
      z += 64'sh8000_0000;
      flip = 1'b1;
    end
    for (i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_TURNS[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_TURNS[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic void beam_endpoint(input beam_t b, output longint px, output longint py);
    logic [15:0] ang;
    longint      cs, sn, rng, ex, ey;
    ang = b.ego_hdg + start_angle_q + b.index * angle_step_q;
    beam_trig(ang, cs, sn);
    rng = longint'(b.range_mm);
    ex  = longint'(b.ego_x);
    ey  = longint'(b.ego_y);
    px  = ex + ((rng * cs + 64'sh2000_0000) >>> 30);
    py  = ey + ((rng * sn + 64'sh2000_0000) >>> 30);
  endfunction

  function automatic logic [15:0] speed_floor(input longint sq);
    longint root, trial;
    int     bitpos;
    root = 0;
    for (bitpos = 15; bitpos >= 0; bitpos--) begin
      trial = root | (64'sd1 << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    return root[15:0];
  endfunction

  // advance the sticky hit flag; a last beam yields the scan report
  function automatic bit score_beam(input beam_t b, output scan_report_t r);
    longint px, py, dx, dy, tx, ty, rr, vx, vy;
    r = '0;
    if (b.index < MAX_BEAMS) begin
      beam_endpoint(b, px, py);
      tx = longint'(b.tgt_x);
      ty = longint'(b.tgt_y);
      dx = px - tx;
      dy = py - ty;
      rr = longint'(hit_radius_q) * longint'(hit_radius_q);
      if (dx * dx + dy * dy < rr) hit_seen_q = 1'b1;
    end
    if (!b.last) return 1'b0;
    if (hit_seen_q) begin
      vx = longint'(b.vx);
      vy = longint'(b.vy);
      r.detected = 1'b1;
      r.x        = b.tgt_x;
      r.y        = b.tgt_y;
      r.heading  = b.tgt_hdg;
      r.speed    = speed_floor(vx * vx + vy * vy);
    end
    hit_seen_q = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic add_beam(input int idx, input int rng, input bit last, input int ex,
                          input int ey, input int eh, input int tx, input int ty,
                          input int th, input int vx, input int vy);
    stim_row_t row;
    row = '{kind: ROW_BEAM, reg_idx: '0, reg_val: '0, beam: '0, typed: 1'b0, want: '0};
    row.beam.index    = 11'(idx);
    row.beam.range_mm = 16'(rng);
    row.beam.last     = last;
    row.beam.ego_x    = 24'(ex);
    row.beam.ego_y    = 24'(ey);
    row.beam.ego_hdg  = 16'(eh);
    row.beam.tgt_x    = 24'(tx);
    row.beam.tgt_y    = 24'(ty);
    row.beam.tgt_hdg  = 16'(th);
    row.beam.vx       = 16'(vx);
    row.beam.vy       = 16'(vy);
    stim_rows.push_back(row);
  endtask

  task automatic want_result(input bit det, input int x, input int y, input int h,
                             input int s);
    scan_report_t w;
    w.detected = det;
    w.x        = 24'(x);
    w.y        = 24'(y);
    w.heading  = 16'(h);
    w.speed    = 16'(s);
    stim_rows[stim_rows.size()-1].typed = 1'b1;
    stim_rows[stim_rows.size()-1].want  = w;
  endtask

  task automatic add_cfg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, beam: '0, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_ANGLE: start_angle_q = val;
      CFG_ANGLE_STEP:  angle_step_q  = val;
      CFG_HIT_RADIUS:  hit_radius_q  = val;
      default: ;
    endcase
  endtask

  // drop the request, drain all reports, then let trailing beams finish
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (scan_reports_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_beam(input beam_t b, input bit typed, input scan_report_t want);
    int unsigned  gap;
    scan_report_t r;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, b.vy, b.vx, b.tgt_hdg, b.tgt_y, b.tgt_x, b.ego_hdg, b.ego_y,
                      b.ego_x, b.range_mm, b.index};
    s_axis_tlast  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (score_beam(b, r)) scan_reports_q.push_back(typed ? want : r);
  endtask

  // result side: random stall per report, one long hold-off to back up the input
  initial begin : receiver
    int unsigned  hold;
    scan_report_t w;
    forever begin
      hold = (report_cnt == 20) ? PRESSURE_CYCLES : (burst ? 0 : $urandom_range(0, 12));
      if (hold != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      report_cnt++;
      if (scan_reports_q.size() == 0) begin
        report_mismatch("report with none pending", {31'b0, m_axis_tuser}, '0);
      end else begin
        w = scan_reports_q.pop_front();
        check_field("detected", 32'(m_axis_tuser), 32'(w.detected));
        check_field("out_x_mm", 32'(m_axis_tdata[23:0]), 32'(w.x));
        check_field("out_y_mm", 32'(m_axis_tdata[47:24]), 32'(w.y));
        check_field("out_heading", 32'(m_axis_tdata[63:48]), 32'(w.heading));
        check_field("out_speed_mm_s", 32'(m_axis_tdata[79:64]), 32'(w.speed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    beam_t        b;
    beam_t        scan [16];
    scan_report_t none;
    logic [15:0]  ph_start [8];
    logic [15:0]  ph_step [8];
    logic [15:0]  ph_rad [8];
    longint       px, py, rad;
    int           ph, items, n, k, j;

    none = '0;

    // own beam on the target, extremes of position and velocity
    add_beam(0, 0, 1, 1000, -2000, 'h1234, 1000, -2000, 'h1234, 3, 4);
    want_result(1, 1000, -2000, 'h1234, 5);
    add_beam(2047, 65535, 1, -8388608, -8388608, 'hFFFF, 8388607, 8388607, 0, 0, 0);
    want_result(0, 0, 0, 0, 0);
    add_beam(0, 0, 1, 8388607, -8388608, 0, 8388607, -8388608, 'hFFFF, -32768, -32768);
    want_result(1, 8388607, -8388608, 'hFFFF, 46340);
    // hit on an early beam, last beam reports its own target
    add_beam(5, 0, 0, 500, 500, 0, 500, 500, 0, 0, 0);
    add_beam(6, 65535, 1, 0, 0, 0, -5000000, 7000, 'h8000, 32767, 0);
    want_result(1, -5000000, 7000, 'h8000, 32767);
    // beam along +x, target on the endpoint, on the radius and just inside it
    add_beam(0, 1000, 1, 0, 0, 'h8000, 1000, 0, 'h0101, 100, -100);
    add_beam(0, 1000, 1, 0, 0, 'h8000, 1300, 0, 'h0202, 0, 0);
    add_beam(0, 1000, 1, 0, 0, 'h8000, 1299, 0, 'h0303, -7, 9);
    // quarter-turn fold boundaries
    add_beam(0, 40000, 1, 0, 0, 'h4000, 0, -40000, 'h4000, 1, 1);
    add_beam(0, 40000, 1, 0, 0, 'hC000, 0, 40000, 'hC000, 2, 2);
    add_beam(0, 65535, 1, 0, 0, 'hC001, 100, 65535, 'hC001, 3, 3);
    add_beam(2047, 30000, 0, -123456, 654321, 'h5A5A, -123456, 684321, 0, 0, 0);
    add_beam(2046, 0, 1, 0, 0, 0, 4000000, 4000000, 'h1111, 500, 500);
    // zero radius never hits
    add_cfg(CFG_HIT_RADIUS, 16'd0);
    add_beam(0, 0, 1, 77, 88, 0, 77, 88, 'h7777, 5, 5);
    want_result(0, 0, 0, 0, 0);
    add_cfg(CFG_HIT_RADIUS, 16'hFFFF);
    add_cfg(CFG_START_ANGLE, 16'h7FFF);
    add_cfg(CFG_ANGLE_STEP, 16'hFFFF);
    add_beam(2047, 65535, 1, 0, 0, 0, 60000, 0, 'h2222, 0, 0);
    add_beam(3, 12345, 1, -8388608, 8388607, 'h3333, -8388608, 8388607, 'h4444, 1, -1);
    add_cfg(CFG_ANGLE_STEP, 16'd0);
    add_cfg(CFG_HIT_RADIUS, 16'd1);
    add_beam(1000, 500, 1, 0, 0, 'h8001, 500, 0, 'h5555, 0, 0);
    add_beam(0, 0, 1, -1, -1, 'h8001, -1, -1, 'h00FF, -1, 0);
    want_result(1, -1, -1, 'h00FF, 1);

    ph_start = '{START_ANGLE_RST, 16'h7FFF, 16'h0000, 16'($urandom), 16'h8000,
                 16'($urandom), 16'h4000, 16'($urandom)};
    ph_step  = '{ANGLE_STEP_RST, 16'h0000, 16'hFFFF, 16'($urandom), 16'd1,
                 16'($urandom), 16'd91, 16'($urandom)};
    ph_rad   = '{HIT_RADIUS_RST, 16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'd3000,
                 16'($urandom_range(1, 2000)), 16'd0, 16'($urandom_range(1, 65535))};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_beam(stim_rows[i].beam, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      settle();
      burst = (ph == 2) || (ph == 5);
      cfg_write(CFG_START_ANGLE, ph_start[ph]);
      cfg_write(CFG_ANGLE_STEP, ph_step[ph]);
      cfg_write(CFG_HIT_RADIUS, ph_rad[ph]);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 2) begin
          b          = '0;
          b.index    = 11'($urandom);
          b.range_mm = 16'($urandom);
          b.last     = ($urandom_range(0, 3) == 0);
          b.ego_x    = 24'($urandom);
          b.ego_y    = 24'($urandom);
          b.ego_hdg  = 16'($urandom);
          b.tgt_x    = 24'($urandom);
          b.tgt_y    = 24'($urandom);
          b.tgt_hdg  = 16'($urandom);
          b.vx       = 16'($urandom);
          b.vy       = 16'($urandom);
          send_beam(b, 1'b0, none);
          items++;
        end else begin
          // well-formed scan: consecutive beams, shared poses, mostly aimed at the target
          n          = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
          b          = '0;
          b.index    = 11'($urandom);
          b.ego_x    = 24'(longint'($urandom_range(0, 8388607)) - 64'sd4194304);
          b.ego_y    = 24'(longint'($urandom_range(0, 8388607)) - 64'sd4194304);
          b.ego_hdg  = 16'($urandom);
          b.tgt_x    = 24'(longint'($urandom_range(0, 8388607)) - 64'sd4194304);
          b.tgt_y    = 24'(longint'($urandom_range(0, 8388607)) - 64'sd4194304);
          b.tgt_hdg  = 16'($urandom);
          b.vx       = 16'($urandom);
          b.vy       = 16'($urandom);
          for (j = 0; j < n; j++) begin
            scan[j]          = b;
            scan[j].index    = 11'(b.index + j);
            scan[j].range_mm = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 5000));
          end
          if ($urandom_range(0, 9) < 7) begin
            k   = $urandom_range(0, n - 1);
            rad = longint'(hit_radius_q);
            beam_endpoint(scan[k], px, py);
            px += longint'($urandom_range(0, 32'(2 * rad))) - rad;
            py += longint'($urandom_range(0, 32'(2 * rad))) - rad;
            for (j = 0; j < n; j++) begin
              scan[j].tgt_x = 24'(px);
              scan[j].tgt_y = 24'(py);
            end
          end
          scan[n-1].last = ($urandom_range(0, 9) != 0);
          for (j = 0; j < n; j++) begin
            send_beam(scan[j], 1'b0, none);
          end
          items += n;
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stpc_pkg.sv
rtl/scan_target_proximity_check.sv
sim/testbench.sv
